[rtl/core/baro_sample_sequencer_compensator_unit_defines.svh]
// Assertion macros shared by the barometer sequencer RTL.
`ifndef BARO_SAMPLE_SEQUENCER_COMPENSATOR_UNIT_DEFINES_SVH
`define BARO_SAMPLE_SEQUENCER_COMPENSATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BSSC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bssc assertion failed");
`define BSSC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bssc reset assertion failed");
`else
`define BSSC_ASSERT(label, prop)
`define BSSC_ASSERT_RST(label, prop)
`endif
`endif

[rtl/core/bssc_pkg.sv]
// Shared types, codes and constants of the barometer sequencer.
package bssc_pkg;

    localparam int NOW_W    = 32;
    localparam int ADC_W    = 24;
    localparam int COEF_W   = 16;
    localparam int WAIT_W   = 20;
    localparam int IVL_W    = 4;
    localparam int ACT_W    = 3;
    localparam int TEMP_W   = 19;
    localparam int PRES_W   = 23;
    localparam int OP_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 48;

    localparam logic [WAIT_W-1:0] WAIT_RST     = 20'd10000;
    localparam logic [IVL_W-1:0]  INTERVAL_RST = 4'd10;
    localparam logic [TEMP_W-1:0] TEMP_BASE    = 19'd2000;
    localparam logic [IVL_W-1:0]  CNT_MAX      = 4'd15;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_WAIT_P = 2'd1;
    localparam logic [1:0] PH_WAIT_T = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE           = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START_P        = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ_P         = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_P_START_T = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_T         = 3'd4;

    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_DT   = 4'd1;
    localparam logic [OP_W-1:0] OP_TMUL = 4'd2;
    localparam logic [OP_W-1:0] OP_TEMP = 4'd3;
    localparam logic [OP_W-1:0] OP_OFF  = 4'd4;
    localparam logic [OP_W-1:0] OP_SENS = 4'd5;
    localparam logic [OP_W-1:0] OP_PLO  = 4'd6;
    localparam logic [OP_W-1:0] OP_PHI  = 4'd7;
    localparam logic [OP_W-1:0] OP_ACC  = 4'd8;
    localparam logic [OP_W-1:0] OP_PRES = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_SENS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TREF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd7;

    typedef struct packed {
        logic              latch_in;
        logic              load_cstart;
        logic              load_press;
        logic              load_temp;
        logic [OP_W-1:0]   op;
        logic              out_load;
        logic [ACT_W-1:0]  action;
        logic              valid;
    } ctrl_cmd_t;

    typedef struct packed {
        logic              done;
        logic [IVL_W-1:0]  interval;
        logic              out_free;
    } dp_stat_t;

endpackage

[rtl/core/baro_sample_sequencer_compensator_unit.sv]
// Top level of the barometer sample sequencer with first-order compensation.
// Each input transaction is one tick: s_axis_tdata carries the microsecond time
// and the ADC word that a read on this tick would return.
// Each tick yields exactly one output transaction with the bus action for the tick,
// a sample flag on m_axis_tuser and, when a sample completes, the compensated
// temperature in hundredths of a degree and the pressure in pascal.
// Coefficients, the conversion wait and the temperature interval are written through
// cfg_we, cfg_index and cfg_wdata; the user must write them only while no tick is in
// flight, which the block itself does not enforce. A tick that completes no sample goes
// from its sequencer step straight to the output register. A tick that completes a
// sample first passes through nine compensation steps, five of which use the shared
// 25 by 18 bit multiplier. One tick is processed at a time; the next tick is accepted
// as soon as the previous result sits in the output register, even if the receiver has
// not taken it yet. When the receiver stalls, the result holds and the block waits
// before loading the next one. Reset is synchronous and active low; it returns the
// sequencer to idle and restores the register defaults.
module baro_sample_sequencer_compensator_unit
    import bssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WAIT_W-1:0]     cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,  // now_us, adc_word
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,  // bus_action, temp_centi, pressure_pa, zero pad
    output logic                  m_axis_tuser   // sample_valid
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    bssc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    bssc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[rtl/core/bssc_ctrl.sv]
// Controller: transaction handshake, conversion sequencer and compensation step control.
`include "baro_sample_sequencer_compensator_unit_defines.svh"
module bssc_ctrl
    import bssc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEQ  = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [IVL_W-1:0] cnt_reg, cnt_next;
    logic             temp_known_reg, temp_known_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [ACT_W-1:0] action_reg, action_next;
    logic             valid_reg, valid_next;
    logic [IVL_W-1:0] cnt_inc;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cnt_inc = (cnt_reg < CNT_MAX) ? cnt_reg + 4'd1 : cnt_reg;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        temp_known_next = temp_known_reg;
        op_next         = op_reg;
        action_next     = action_reg;
        valid_next      = valid_reg;
        cmd             = '0;
        cmd.action      = action_reg;
        cmd.valid       = valid_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_SEQ;
                end
            end
            S_SEQ: begin
                action_next = ACT_NONE;
                valid_next  = 1'b0;
                if (phase_reg == PH_WAIT_P) begin
                    if (stat.done) begin
                        cmd.load_press = 1'b1;
                        cnt_next = cnt_inc;
                        if (!temp_known_reg || cnt_inc >= stat.interval) begin
                            action_next     = ACT_READ_P_START_T;
                            cmd.load_cstart = 1'b1;
                            phase_next      = PH_WAIT_T;
                        end else begin
                            action_next = ACT_READ_P;
                            valid_next  = 1'b1;
                            phase_next  = PH_IDLE;
                        end
                    end
                end else if (phase_reg == PH_WAIT_T) begin
                    if (stat.done) begin
                        cmd.load_temp   = 1'b1;
                        temp_known_next = 1'b1;
                        cnt_next        = '0;
                        action_next     = ACT_READ_T;
                        valid_next      = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                end else begin
                    action_next     = ACT_START_P;
                    cmd.load_cstart = 1'b1;
                    phase_next      = PH_WAIT_P;
                end
                op_next    = OP_DT;
                state_next = valid_next ? S_CALC : S_OUT;
            end
            S_CALC: begin
                cmd.op  = op_reg;
                op_next = op_reg + 4'd1;
                if (op_reg == OP_PRES) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            cnt_reg        <= '0;
            temp_known_reg <= 1'b0;
            op_reg         <= OP_NONE;
            action_reg     <= ACT_NONE;
            valid_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            temp_known_reg <= temp_known_next;
            op_reg         <= op_next;
            action_reg     <= action_next;
            valid_reg      <= valid_next;
        end
    end

    `BSSC_ASSERT(a_accept_to_seq, (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_SEQ))
    `BSSC_ASSERT(a_calc_only_for_samples, (state_reg == S_CALC) |-> (valid_reg && (action_reg == ACT_READ_P || action_reg == ACT_READ_T)))
    `BSSC_ASSERT(a_temp_read_clears, (state_reg == S_SEQ && phase_reg == PH_WAIT_T && stat.done) |=> (temp_known_reg && cnt_reg == '0 && phase_reg == PH_IDLE))
    `BSSC_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == S_IDLE && phase_reg == PH_IDLE))

endmodule

[rtl/core/bssc_datapath.sv]
// Datapath: configuration registers, raw sample storage, shared multiplier and output register.
module bssc_datapath
    import bssc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WAIT_W-1:0]     cfg_wdata,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    output logic                  m_axis_tuser,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat
);

    logic [COEF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic [WAIT_W-1:0] wait_reg;
    logic [IVL_W-1:0]  interval_reg;

    logic [NOW_W-1:0]  now_reg, cstart_reg, elapsed;
    logic [ADC_W-1:0]  adc_reg, raw_press_reg, raw_temp_reg;

    logic signed [24:0] dt_reg;
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] mul_prod, prod_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic signed [35:0] off_reg;
    logic signed [33:0] sens_reg;
    logic signed [57:0] acc_reg;
    logic signed [37:0] pres_diff;
    logic [PRES_W-1:0]  pres_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    assign elapsed       = now_reg - cstart_reg;
    assign stat.done     = (elapsed >= {{(NOW_W-WAIT_W){1'b0}}, wait_reg});
    assign stat.interval = interval_reg;
    assign stat.out_free = !m_tvalid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg       <= '0;
            c2_reg       <= '0;
            c3_reg       <= '0;
            c4_reg       <= '0;
            c5_reg       <= '0;
            c6_reg       <= '0;
            wait_reg     <= WAIT_RST;
            interval_reg <= INTERVAL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SENS:      c1_reg       <= cfg_wdata[COEF_W-1:0];
                CFG_OFFSET:    c2_reg       <= cfg_wdata[COEF_W-1:0];
                CFG_SENS_TC:   c3_reg       <= cfg_wdata[COEF_W-1:0];
                CFG_OFFSET_TC: c4_reg       <= cfg_wdata[COEF_W-1:0];
                CFG_TREF:      c5_reg       <= cfg_wdata[COEF_W-1:0];
                CFG_SLOPE:     c6_reg       <= cfg_wdata[COEF_W-1:0];
                CFG_WAIT:      wait_reg     <= cfg_wdata;
                CFG_INTERVAL:  interval_reg <= cfg_wdata[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cstart_reg    <= '0;
            raw_press_reg <= '0;
            raw_temp_reg  <= '0;
        end else begin
            if (cmd.load_cstart) begin
                cstart_reg <= now_reg;
            end
            if (cmd.load_press) begin
                raw_press_reg <= adc_reg;
            end
            if (cmd.load_temp) begin
                raw_temp_reg <= adc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            now_reg <= s_axis_tdata[NOW_W-1:0];
            adc_reg <= s_axis_tdata[NOW_W+ADC_W-1:NOW_W];
        end
    end

    always_comb begin
        mul_a = dt_reg;
        mul_b = '0;
        case (cmd.op)
            OP_TMUL: mul_b = $signed({2'b00, c6_reg});
            OP_TEMP: mul_b = $signed({2'b00, c4_reg});
            OP_OFF:  mul_b = $signed({2'b00, c3_reg});
            OP_PLO: begin
                mul_a = $signed({1'b0, raw_press_reg});
                mul_b = $signed({1'b0, sens_reg[16:0]});
            end
            OP_PHI: begin
                mul_a = $signed({1'b0, raw_press_reg});
                mul_b = $signed({sens_reg[33], sens_reg[33:17]});
            end
            default: begin
            end
        endcase
    end

    assign mul_prod  = mul_a * mul_b;
    assign pres_diff = $signed({acc_reg[57], acc_reg[57:21]}) - $signed({{2{off_reg[35]}}, off_reg});

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_DT: begin
                dt_reg <= $signed({1'b0, raw_temp_reg}) - $signed({1'b0, c5_reg, 8'h00});
            end
            OP_TMUL: begin
                prod_reg <= mul_prod;
            end
            OP_TEMP: begin
                temp_reg <= prod_reg[41:23] + TEMP_BASE;
                prod_reg <= mul_prod;
            end
            OP_OFF: begin
                off_reg  <= $signed(prod_reg[42:7]) + $signed({4'h0, c2_reg, 16'h0000});
                prod_reg <= mul_prod;
            end
            OP_SENS: begin
                sens_reg <= $signed(prod_reg[41:8]) + $signed({3'b000, c1_reg, 15'h0000});
            end
            OP_PLO: begin
                prod_reg <= mul_prod;
            end
            OP_PHI: begin
                acc_reg  <= {{15{prod_reg[42]}}, prod_reg};
                prod_reg <= mul_prod;
            end
            OP_ACC: begin
                acc_reg <= acc_reg + $signed({prod_reg[40:0], 17'h00000});
            end
            OP_PRES: begin
                pres_reg <= pres_diff[37:15];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {3'b000,
                            cmd.valid ? pres_reg : {PRES_W{1'b0}},
                            cmd.valid ? temp_reg : {TEMP_W{1'b0}},
                            cmd.action};
            m_tuser_reg <= cmd.valid;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule
